// ===== sv/ils_pkg.sv =====
`default_nettype none

package ils_pkg;

    // List capacity and derived widths
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int LEN_W    = 7;
    localparam int STAT_W   = 2;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int CMP1_W   = CMP_W + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ   = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_QUERY  = 3'd4
    } cmd_e;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2
    } status_e;

    // Controller -> datapath
    typedef struct packed {
        logic load;
        logic decode;
        logic step;
        logic commit;
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic need_shift;
        logic last_step;
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== sv/ils_ram.sv =====
`default_nettype none

module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/ils_ctrl.sv =====
`default_nettype none

module ils_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ils_pkg::dp_sts_t  sts,
    output ils_pkg::dp_cmd_t  cmd
);

    import ils_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_SHIFT  = 5'b00100,
        S_TAIL   = 5'b01000,
        S_COMMIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = sts.need_shift ? S_SHIFT : S_COMMIT;
            end
            S_SHIFT:
            begin
                cmd.step = 1'b1;
                if (sts.last_step)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                // last moved word is written back this cycle
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ===== sv/ils_datapath.sv =====
`default_nettype none

module ils_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ils_pkg::dp_cmd_t              cmd,
    output ils_pkg::dp_sts_t              sts,
    input  logic [ils_pkg::CMD_W-1:0]     command,
    input  logic [ils_pkg::POS_W-1:0]     position,
    input  logic signed [ils_pkg::DATA_W-1:0] value,
    output logic                          done,
    output logic [ils_pkg::STAT_W-1:0]    status,
    output logic signed [ils_pkg::DATA_W-1:0] read_value,
    output logic [ils_pkg::LEN_W-1:0]     length,
    output logic                          is_empty
);

    import ils_pkg::*;

    logic [CMD_W-1:0]  op_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [DATA_W-1:0] val_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  idx_next;
    logic [CNT_W-1:0]  src_idx;
    logic              wpend_reg;
    logic [ADDR_W-1:0] waddr_reg;
    logic              done_reg;
    status_e           status_reg;
    status_e           status_next;
    logic [DATA_W-1:0] read_value_reg;
    logic [LEN_W-1:0]  length_reg;
    logic              empty_reg;

    logic              is_rd;
    logic              is_ins;
    logic              is_del;
    logic              is_clr;
    logic [CMP_W-1:0]  pos_c;
    logic [CMP_W-1:0]  cnt_c;
    logic [CMP1_W-1:0] pos1_c;
    logic [CMP1_W-1:0] cnt1_c;
    logic [CMP1_W-1:0] idx1_c;
    logic              bad_at;
    logic              bad_ins;
    logic              full;
    logic              op_bad;
    logic              op_full;
    logic              op_ok;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    assign is_rd  = (op_reg == CMD_READ);
    assign is_ins = (op_reg == CMD_INSERT);
    assign is_del = (op_reg == CMD_DELETE);
    assign is_clr = (op_reg == CMD_CLEAR);

    assign pos_c  = CMP_W'(pos_reg);
    assign cnt_c  = CMP_W'(count_reg);
    assign pos1_c = CMP1_W'(pos_c) + CMP1_W'(1);
    assign cnt1_c = CMP1_W'(cnt_c);
    assign idx1_c = CMP1_W'(idx_reg);

    assign bad_at  = (pos_c >= cnt_c);
    assign bad_ins = (pos_c > cnt_c);
    assign full    = (count_reg == CNT_W'(CAPACITY));

    assign op_bad  = ((is_rd || is_del) && bad_at) || (is_ins && bad_ins);
    assign op_full = is_ins && !bad_ins && full;
    assign op_ok   = !op_bad && !op_full;

    // insert at the tail or delete of the last element moves nothing
    assign sts.need_shift = op_ok && ((is_ins && (pos_c != cnt_c)) ||
                                      (is_del && (pos1_c != cnt1_c)));
    assign sts.last_step  = is_ins ? (idx1_c == pos1_c)
                                   : ((idx1_c + CMP1_W'(2)) == cnt1_c);

    // idx_reg is the destination slot; source is one slot away
    assign src_idx = is_ins ? (idx_reg - CNT_W'(1)) : (idx_reg + CNT_W'(1));

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.decode)
        begin
            idx_next = is_ins ? count_reg : CNT_W'(pos_reg);
        end
        else if (cmd.step)
        begin
            idx_next = src_idx;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (is_clr)
        begin
            count_next = '0;
        end
        else if (is_ins && op_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (is_del && op_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        if (op_bad)
        begin
            status_next = ST_BAD_INDEX;
        end
        else if (op_full)
        begin
            status_next = ST_FULL;
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    assign ram_re    = cmd.decode || cmd.step;
    assign ram_raddr = cmd.step ? src_idx[ADDR_W-1:0] : ADDR_W'(pos_reg);
    assign ram_we    = wpend_reg || (cmd.commit && is_ins && op_ok);
    assign ram_waddr = wpend_reg ? waddr_reg : ADDR_W'(pos_reg);
    assign ram_wdata = wpend_reg ? ram_rdata : val_reg;

    ils_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            wpend_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            wpend_reg <= cmd.step;
            done_reg  <= cmd.commit;
            if (cmd.commit)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load)
        begin
            op_reg  <= command;
            pos_reg <= position;
            val_reg <= value;
        end
        if (cmd.step)
        begin
            waddr_reg <= idx_reg[ADDR_W-1:0];
        end
        if (cmd.commit)
        begin
            status_reg     <= status_next;
            read_value_reg <= (is_rd && op_ok) ? ram_rdata : '0;
            length_reg     <= LEN_W'(count_next);
            empty_reg      <= (count_next == '0);
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign length     = length_reg;
    assign is_empty   = empty_reg;

endmodule

`default_nettype wire

// ===== sv/indexed_list_store.sv =====
// Channel   Handshake               Signals
// command   start & !busy accepts   command, position, value
// result    done (one-cycle pulse)  status, read_value, length, is_empty
//
// Sequence: read, clear, query, a failed command, an append or a delete of the
// last element run decode and commit before the done pulse. Insert and delete
// that move k elements (k up to CAPACITY-1) add shift and tail states: one
// element moves per cycle through the single write port of the element RAM.
// Reset: rst_n clears the list length and the controller; RAM contents are
// left as they are, since only entries below the length are ever used.
// Stalls: the receiver cannot stall; busy holds off the sender for the
// whole transaction.
`default_nettype none

module indexed_list_store (
    input  logic                              clk,
    input  logic                              rst_n,
    // command channel
    input  logic                              start,
    output logic                              busy,
    input  logic [ils_pkg::CMD_W-1:0]         command,
    input  logic [ils_pkg::POS_W-1:0]         position,
    input  logic signed [ils_pkg::DATA_W-1:0] value,
    // result channel
    output logic                              done,
    output logic [ils_pkg::STAT_W-1:0]        status,
    output logic signed [ils_pkg::DATA_W-1:0] read_value,
    output logic [ils_pkg::LEN_W-1:0]         length,
    output logic                              is_empty
);

    import ils_pkg::*;

    // controller sequences decode, element moves, write-back and commit
    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    ils_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (dp_sts),
        .cmd   (dp_cmd)
    );

    // datapath holds the length, the element RAM and the result registers
    ils_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dp_cmd),
        .sts        (dp_sts),
        .command    (command),
        .position   (position),
        .value      (value),
        .done       (done),
        .status     (status),
        .read_value (read_value),
        .length     (length),
        .is_empty   (is_empty)
    );

endmodule

`default_nettype wire

// ===== sv/ils_checker.sv =====
`default_nettype none

module ils_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic [ils_pkg::CMD_W-1:0]         command,
    input logic [ils_pkg::POS_W-1:0]         position,
    input logic signed [ils_pkg::DATA_W-1:0] value,
    input logic                              done,
    input logic [ils_pkg::STAT_W-1:0]        status,
    input logic signed [ils_pkg::DATA_W-1:0] read_value,
    input logic [ils_pkg::LEN_W-1:0]         length,
    input logic                              is_empty
);

    import ils_pkg::*;

    // an accepted transaction keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    // the transaction ends exactly when its result is shown
    a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // one result per transaction
    a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_empty == (length == '0)))
        else $error("empty flag disagrees with length");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> (read_value == '0))
        else $error("failed command returned a read value");

endmodule

bind indexed_list_store ils_checker u_ils_checker (.*);

`default_nettype wire
